// ===== rtl/wspm_pkg.sv =====
// Shared types, constants and the star-closure function for the wildcard star
// pattern matcher. No dependencies; imported by every module in rtl/.
`timescale 1ns / 1ps

package wspm_pkg;

	// Pattern capacity and derived widths
	localparam int MAX_TOKENS = 32;
	localparam int POS_W      = MAX_TOKENS + 1;          // live position vector
	localparam int CNT_W      = $clog2(MAX_TOKENS + 1);  // token count
	localparam int IDX_W      = 5;                       // token_index field
	localparam int BYTE_W     = 8;

	// Stream payload widths
	localparam int IN_DATA_W  = 24;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 8;

	// Request kinds carried on tuser
	typedef enum logic [IN_USER_W-1:0] {
		REQ_CLEAR = 2'd0,
		REQ_LOAD  = 2'd1,
		REQ_TEXT  = 2'd2,
		REQ_EMPTY = 2'd3
	} req_t;

	// Stored pattern as seen by the match logic
	typedef struct packed {
		logic [MAX_TOKENS-1:0][BYTE_W-1:0] tok_bytes;
		logic [MAX_TOKENS-1:0]             any_f;
		logic [MAX_TOKENS-1:0]             star_f;
		logic [CNT_W-1:0]                  count;
	} pat_t;

	// Result of one step of the automaton
	typedef struct packed {
		logic [POS_W-1:0] live_next;
		logic             has_result;
		logic             matched;
	} step_t;

	// Close a position set over starred tokens: position j+1 becomes live when
	// position j is live and token j may be skipped. Parallel prefix (log depth)
	// so a chain of stars propagates combinationally.
	function automatic logic [POS_W-1:0] close_stars(
		input logic [POS_W-1:0]      set_in,
		input logic [MAX_TOKENS-1:0] skip
	);
		logic [POS_W-1:0] g;
		logic [POS_W-1:0] p;
		logic [POS_W-1:0] gn;
		logic [POS_W-1:0] pn;
		g = set_in;
		p = {skip, 1'b0};
		for (int d = 1; d < POS_W; d = d * 2) begin
			gn = g;
			pn = p;
			for (int j = d; j < POS_W; j++) begin
				gn[j] = g[j] | (p[j] & g[j-d]);
				pn[j] = p[j] & p[j-d];
			end
			g = gn;
			p = pn;
		end
		return g;
	endfunction

endpackage

// ===== rtl/wspm_token_store.sv =====
// Token store: byte, any flag and star flag per pattern position, plus the
// token count. Depends on wspm_pkg.
`timescale 1ns / 1ps

module wspm_token_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear,
	input  logic                        load,
	input  logic [wspm_pkg::IDX_W-1:0]  load_idx,
	input  logic [wspm_pkg::BYTE_W-1:0] load_byte,
	input  logic                        load_any,
	input  logic                        load_star,
	output wspm_pkg::pat_t              pat
);
	import wspm_pkg::*;

	logic [MAX_TOKENS-1:0][BYTE_W-1:0] bytes_q;
	logic [MAX_TOKENS-1:0]             any_q;
	logic [MAX_TOKENS-1:0]             star_q;
	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W:0]                    idx_ext;
	logic [CNT_W:0]                    idx_plus;

	assign idx_ext  = (CNT_W + 1)'(load_idx);
	assign idx_plus = idx_ext + (CNT_W + 1)'(1);

	// Entry storage, written one entry per load; no reset
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_TOKENS; i++) begin
			if (load && idx_ext == (CNT_W + 1)'(i)) begin
				bytes_q[i] <= load_byte;
				any_q[i]   <= load_any;
				star_q[i]  <= load_star;
			end
		end
	end

	// Token count: highest loaded index plus one since reset or the last clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (load && idx_ext < (CNT_W + 1)'(MAX_TOKENS)) begin
			if (idx_plus > (CNT_W + 1)'(count_q))
				count_q <= idx_plus[CNT_W-1:0];
		end
	end

	assign pat.tok_bytes = bytes_q;
	assign pat.any_f     = any_q;
	assign pat.star_f    = star_q;
	assign pat.count     = count_q;

endmodule

// ===== rtl/wspm_step.sv =====
// Combinational automaton step: consumes one request against the live position
// set and the stored pattern. Depends on wspm_pkg.
`timescale 1ns / 1ps

module wspm_step (
	input  wspm_pkg::pat_t              pat,
	input  logic [wspm_pkg::POS_W-1:0]  live,
	input  wspm_pkg::req_t              req,
	input  logic [wspm_pkg::BYTE_W-1:0] text_byte,
	input  logic                        first_byte,
	input  logic                        final_item,
	output wspm_pkg::step_t             res
);
	import wspm_pkg::*;

	logic [MAX_TOKENS-1:0] in_pat;
	logic [MAX_TOKENS-1:0] skip;
	logic [MAX_TOKENS-1:0] hit;
	logic [MAX_TOKENS-1:0] stay;
	logic [MAX_TOKENS-1:0] adv;
	logic [POS_W-1:0]      start_set;
	logic [POS_W-1:0]      live_eff;
	logic [POS_W-1:0]      moved;
	logic [POS_W-1:0]      text_next;

	// Positions inside the current pattern, and which of them can be skipped
	always_comb begin
		for (int i = 0; i < MAX_TOKENS; i++)
			in_pat[i] = CNT_W'(i) < pat.count;
	end
	assign skip = in_pat & pat.star_f;

	assign start_set = close_stars(POS_W'(1), skip);
	assign live_eff  = first_byte ? start_set : live;

	// Per-position byte compare, then advance or stay on a starred token
	always_comb begin
		for (int i = 0; i < MAX_TOKENS; i++)
			hit[i] = live_eff[i] & in_pat[i] & (pat.any_f[i] | pat.tok_bytes[i] == text_byte);
	end
	assign stay      = hit & pat.star_f;
	assign adv       = hit & ~pat.star_f;
	assign moved     = {adv, 1'b0} | {1'b0, stay};
	assign text_next = close_stars(moved, skip);

	// Request decode
	always_comb begin
		res.live_next  = live;
		res.has_result = 1'b0;
		res.matched    = 1'b0;
		case (req)
			REQ_CLEAR: begin
				res.live_next = '0;
			end
			REQ_LOAD: begin
				res.live_next = live;
			end
			REQ_TEXT: begin
				res.live_next  = text_next;
				res.has_result = final_item;
				res.matched    = text_next[pat.count];
			end
			REQ_EMPTY: begin
				res.has_result = 1'b1;
				res.matched    = start_set[pat.count];
			end
			default: begin
				res.live_next = live;
			end
		endcase
	end

endmodule

// ===== rtl/wildcard_star_pattern_matcher_core.sv =====
// Top level of the wildcard star pattern matcher: input register, token store,
// automaton step and result register. Depends on wspm_pkg, wspm_token_store, wspm_step.
`timescale 1ns / 1ps

// Takes one request per clock unless a waiting result stalls it: clear, token
// load, text byte or empty-text query, selected by s_axis_tuser. Every request
// enters an input register and completes from there through the automaton step,
// which does the whole live-position update (byte compare on all positions plus
// star closure) combinationally; so one item per cycle is sustained while no
// result stalls it. A request passes the input register and then the result
// register before m_axis_tvalid rises. Only a text byte with tlast set or an
// empty-text query produces a result (matched in m_axis_tdata bit 0). While a
// result waits on the master side, requests that produce no result keep
// flowing; one that does waits in the input register. The token store needs
// no clearing pass after reset. Gaps in a loaded pattern read as undefined.
module wildcard_star_pattern_matcher_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [4:0] token_index, [12:5] token_byte, [13] token_any, [14] token_star,
	// [22:15] text_byte, [23] first_byte
	input  logic [wspm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [1:0] req_type
	input  logic [wspm_pkg::IN_USER_W-1:0]   s_axis_tuser,
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [0] matched, [7:1] zero
	output logic [wspm_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import wspm_pkg::*;

	logic                valid_s1;
	req_t                req_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [BYTE_W-1:0]   tok_byte_s1;
	logic                tok_any_s1;
	logic                tok_star_s1;
	logic [BYTE_W-1:0]   text_byte_s1;
	logic                first_s1;
	logic                last_s1;

	logic [POS_W-1:0]    live_q;
	logic                out_valid_q;
	logic                out_matched_q;

	pat_t                pat;
	step_t               res;
	logic                s1_fire;
	logic                in_xfer;

	// Input register handshake
	assign s1_fire       = valid_s1 & (~res.has_result | ~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | s1_fire;
	assign in_xfer       = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_s1       <= req_t'(s_axis_tuser);
			idx_s1       <= s_axis_tdata[4:0];
			tok_byte_s1  <= s_axis_tdata[12:5];
			tok_any_s1   <= s_axis_tdata[13];
			tok_star_s1  <= s_axis_tdata[14];
			text_byte_s1 <= s_axis_tdata[22:15];
			first_s1     <= s_axis_tdata[23];
			last_s1      <= s_axis_tlast;
		end
	end

	// Pattern storage
	wspm_token_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (s1_fire && req_s1 == REQ_CLEAR),
		.load      (s1_fire && req_s1 == REQ_LOAD),
		.load_idx  (idx_s1),
		.load_byte (tok_byte_s1),
		.load_any  (tok_any_s1),
		.load_star (tok_star_s1),
		.pat       (pat)
	);

	// Automaton step
	wspm_step u_step (
		.pat        (pat),
		.live       (live_q),
		.req        (req_s1),
		.text_byte  (text_byte_s1),
		.first_byte (first_s1),
		.final_item (last_s1),
		.res        (res)
	);

	// Live position set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			live_q <= '0;
		else if (s1_fire)
			live_q <= res.live_next;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_fire && res.has_result)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res.has_result)
			out_matched_q <= res.matched;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - 1)'(0), out_matched_q};

`ifndef ASSERT_OFF
	// A clear empties both the pattern and the live set
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && req_s1 == REQ_CLEAR |=> live_q == '0 && pat.count == '0)
		else $error("clear did not empty pattern and live set");

	// The token count never exceeds the store depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		pat.count <= CNT_W'(MAX_TOKENS))
		else $error("token count beyond store depth");

	// An empty-text query always yields a result and leaves the live set alone
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && req_s1 == REQ_EMPTY |=> m_axis_tvalid && $stable(live_q))
		else $error("empty-text query lost or disturbed live set");

	// A request that completes with a result finds the result slot free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && res.has_result |-> !out_valid_q || m_axis_tready)
		else $error("pending result overwritten");
`endif

endmodule

// ===== verif/wspm_match_checker.sv =====
// Scoreboard for the wildcard star pattern matcher: watches both stream channels,
// tracks the pattern and live positions, and checks every match result. Depends on wspm_pkg.
`timescale 1ns / 1ps

module wspm_match_checker
	import wspm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	input  logic                  s_axis_tlast,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	output int                    errors,
	output int                    pending
);

	// Shadow pattern and automaton state
	logic [BYTE_W-1:0] pat_byte [MAX_TOKENS];
	logic              pat_any  [MAX_TOKENS];
	logic              pat_star [MAX_TOKENS];
	int                pat_count;
	logic [POS_W-1:0]  live_set;
	logic              expected_matches [$];
	logic              want_match;

	initial begin
		errors  = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string what);
		$display("%0t ERROR: %s", $realtime, what);
		errors++;
	endtask

	// Skippable tokens: a live position in front of a starred token also makes
	// the next one live; ascending order lets chains of stars propagate.
	function automatic logic [POS_W-1:0] star_closure(input logic [POS_W-1:0] set_in);
		logic [POS_W-1:0] set_out;
		set_out = set_in;
		for (int i = 0; i < pat_count; i++)
			if (set_out[i] && pat_star[i])
				set_out[i+1] = 1'b1;
		return set_out;
	endfunction

	// Apply one accepted request; queue the match bit when one is due
	task automatic track_request(
		input req_t                 kind,
		input logic [IN_DATA_W-1:0] data,
		input logic                 fin
	);
		logic [IDX_W-1:0]  idx;
		logic [BYTE_W-1:0] txt;
		logic              first;
		logic [POS_W-1:0]  nxt;
		idx   = data[4:0];
		txt   = data[22:15];
		first = data[23];
		case (kind)
			REQ_CLEAR: begin
				pat_count = 0;
				live_set  = '0;
			end
			REQ_LOAD: begin
				pat_byte[idx] = data[12:5];
				pat_any[idx]  = data[13];
				pat_star[idx] = data[14];
				if (int'(idx) + 1 > pat_count)
					pat_count = int'(idx) + 1;
			end
			REQ_EMPTY: begin
				nxt = star_closure(POS_W'(1));
				expected_matches = {expected_matches, nxt[pat_count]};
			end
			default: begin
				// text byte: optional restart, then shift live positions over matches
				if (first)
					live_set = star_closure(POS_W'(1));
				nxt = '0;
				for (int i = 0; i < pat_count; i++) begin
					if (live_set[i] && (pat_any[i] || pat_byte[i] == txt)) begin
						if (pat_star[i])
							nxt[i] = 1'b1;
						else
							nxt[i+1] = 1'b1;
					end
				end
				live_set = star_closure(nxt);
				if (fin)
					expected_matches = {expected_matches, live_set[pat_count]};
			end
		endcase
	endtask

	// Compare results first: a result can never stem from a request of the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_count = 0;
			live_set  = '0;
			expected_matches.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_matches.size() == 0) begin
					report_mismatch($sformatf("result %h with none outstanding", m_axis_tdata));
				end else begin
					want_match = expected_matches.pop_front();
					if (m_axis_tdata[0] !== want_match)
						report_mismatch($sformatf("matched %b, want %b",
							m_axis_tdata[0], want_match));
					if (m_axis_tdata[OUT_DATA_W-1:1] !== '0)
						report_mismatch($sformatf("pad bits %h not zero",
							m_axis_tdata[OUT_DATA_W-1:1]));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				track_request(req_t'(s_axis_tuser), s_axis_tdata, s_axis_tlast);
		end
		pending = expected_matches.size();
	end

endmodule

// ===== verif/tb_wildcard_star_pattern_matcher_core.sv =====
// Testbench top for the wildcard star pattern matcher: clock, reset, request
// stimulus and result sink. Depends on wspm_pkg, wspm_match_checker and the core RTL.
`timescale 1ns / 1ps

module tb_wildcard_star_pattern_matcher_core;
	import wspm_pkg::*;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// [4:0] token_index, [12:5] token_byte, [13] token_any, [14] token_star,
	// [22:15] text_byte, [23] first_byte
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	// [1:0] req_type
	logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
	logic                  s_axis_tlast  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [0] matched, [7:1] zero
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	int errors;
	int pending;

	// Stimulus knobs and bookkeeping
	int  sent          = 0;
	int  src_gap_pct   = 0;
	int  sink_stall_pct = 0;
	bit  calm          = 1'b0;
	bit  hold_off      = 1'b0;

	// Stimulus-side view of the pattern, used to build matching texts
	logic [BYTE_W-1:0]     gen_byte [MAX_TOKENS];
	bit                    gen_any  [MAX_TOKENS];
	bit                    gen_star [MAX_TOKENS];
	int                    gen_len  = 0;
	bit [MAX_TOKENS-1:0]   written  = '0;

	always #5 clk = ~clk;

	wildcard_star_pattern_matcher_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	wspm_match_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.errors        (errors),
		.pending       (pending)
	);

	// Mostly a tiny alphabet so texts actually match, now and then any byte
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(0, 255));
		return 8'("a" + $urandom_range(0, 2));
	endfunction

	// One transfer on the request side; valid stays high between items unless a source gap is drawn
	task automatic send_req(
		input req_t        kind,
		input logic [4:0]  idx,
		input logic [7:0]  tok_b,
		input logic        tok_any,
		input logic        tok_star,
		input logic [7:0]  txt,
		input logic        first,
		input logic        fin
	);
		if (!calm && $urandom_range(0, 99) < src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {first, txt, tok_star, tok_any, tok_b, idx};
		s_axis_tlast  <= fin;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent++;
	endtask

	// Clear or empty-text query; unused fields carry junk
	task automatic ctl_req(input req_t kind);
		if (kind == REQ_CLEAR)
			gen_len = 0;
		send_req(kind, 5'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
			8'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic load_token(
		input int         idx,
		input logic [7:0] b,
		input bit         any_f,
		input bit         star_f,
		input bit         fin
	);
		gen_byte[idx] = b;
		gen_any[idx]  = any_f;
		gen_star[idx] = star_f;
		written[idx]  = 1'b1;
		if (idx + 1 > gen_len)
			gen_len = idx + 1;
		send_req(REQ_LOAD, 5'(idx), b, any_f, star_f, 8'($urandom), 1'($urandom), fin);
	endtask

	task automatic text_req(input logic [7:0] b, input bit first, input bit fin);
		send_req(REQ_TEXT, 5'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
			b, first, fin);
	endtask

	// Fresh pattern of n tokens, loaded in ascending or descending order
	task automatic new_pattern(input int n);
		bit desc;
		int i;
		desc = $urandom_range(0, 1);
		ctl_req(REQ_CLEAR);
		for (int k = 0; k < n; k++) begin
			i = desc ? n - 1 - k : k;
			load_token(i, pick_byte(), $urandom_range(0, 4) == 0,
				$urandom_range(0, 2) == 0, k == n - 1);
		end
	endtask

	// Whole text: built from the pattern (maybe with one corrupted or extra byte) or random
	task automatic run_text(input bit conform);
		logic [7:0] txt_q [$];
		int reps;
		txt_q.delete();
		if (conform) begin
			for (int i = 0; i < gen_len; i++) begin
				reps = gen_star[i] ? $urandom_range(0, 3) : 1;
				repeat (reps)
					txt_q = {txt_q, gen_any[i] ? pick_byte() : gen_byte[i]};
			end
			if ($urandom_range(0, 3) == 0) begin
				if (txt_q.size() > 0 && $urandom_range(0, 1))
					txt_q[$urandom_range(0, txt_q.size() - 1)] = pick_byte();
				else
					txt_q = {txt_q, pick_byte()};
			end
		end else begin
			repeat ($urandom_range(0, 6))
				txt_q = {txt_q, pick_byte()};
		end
		if (txt_q.size() == 0)
			ctl_req(REQ_EMPTY);
		else
			foreach (txt_q[j])
				text_req(txt_q[j], j == 0, j == txt_q.size() - 1);
	endtask

	// Result sink: random short stalls, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				repeat (48) @(posedge clk);
				hold_off = 1'b0;
			end else if (!calm && $urandom_range(0, 99) < sink_stall_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Watchdog
	initial begin
		#3000000;
		$display("Verification failed");
		$finish;
	end

	// Main stimulus
	initial begin
		int  roll;
		int  prefix;
		int  phase_mark;
		bit  held;
		bit  first_pat;
		phase_mark = 0;
		held       = 1'b0;
		first_pat  = 1'b1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty pattern, star skip, dot, extremes, pattern edits mid-text
		ctl_req(REQ_CLEAR);
		ctl_req(REQ_EMPTY);
		text_req(8'h61, 1, 1);
		load_token(0, 8'hFF, 0, 1, 1);
		ctl_req(REQ_EMPTY);
		text_req(8'hFF, 1, 1);
		text_req(8'h00, 1, 1);
		load_token(1, 8'h00, 1, 0, 1);
		text_req(8'hFF, 1, 0);
		text_req(8'hFF, 0, 0);
		text_req(8'h00, 0, 1);
		text_req(8'h5A, 0, 1);
		load_token(2, 8'h00, 0, 0, 0);
		text_req(8'h80, 1, 0);
		load_token(2, 8'h7F, 0, 1, 1);
		text_req(8'h7F, 0, 1);
		ctl_req(REQ_CLEAR);
		text_req(8'h01, 0, 1);
		load_token(0, 8'h00, 1, 1, 0);
		ctl_req(REQ_EMPTY);
		text_req(8'hC3, 1, 1);

		// Random traffic
		while (sent < 650) begin
			if (sent >= 560)
				calm = 1'b1;
			if (sent - phase_mark >= 80) begin
				phase_mark     = sent;
				src_gap_pct    = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(10, 40);
				sink_stall_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(10, 40);
			end
			// long sink hold-off while result-producing requests keep coming
			if (!held && sent >= 300) begin
				held     = 1'b1;
				hold_off = 1'b1;
				repeat (12) ctl_req(REQ_EMPTY);
			end
			roll = $urandom_range(0, 99);
			if (first_pat || roll < 15) begin
				new_pattern(first_pat || $urandom_range(0, 24) == 0 ? MAX_TOKENS
					: $urandom_range(0, 6));
				first_pat = 1'b0;
			end else if (roll < 65) begin
				run_text(1'b1);
			end else if (roll < 80) begin
				run_text(1'b0);
			end else begin
				// noise: stray controls, loads and unframed bytes
				case ($urandom_range(0, 3))
					0: ctl_req(REQ_CLEAR);
					1: begin
						prefix = 0;
						while (prefix < MAX_TOKENS && written[prefix])
							prefix++;
						load_token($urandom_range(0, prefix < MAX_TOKENS ? prefix
							: MAX_TOKENS - 1), pick_byte(), $urandom_range(0, 1),
							$urandom_range(0, 1), $urandom_range(0, 1));
					end
					2: text_req(pick_byte(), $urandom_range(0, 1), $urandom_range(0, 1));
					default: ctl_req(REQ_EMPTY);
				endcase
			end
		end
		s_axis_tvalid <= 1'b0;

		// Drain, then allow for the pipeline latency
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/wspm_pkg.sv
rtl/wspm_token_store.sv
rtl/wspm_step.sv
rtl/wildcard_star_pattern_matcher_core.sv
verif/wspm_match_checker.sv
verif/tb_wildcard_star_pattern_matcher_core.sv
